// File: rtl/bed_pkg.sv
// Package for the button event detector: trigger mode codes, register
// indexes and fixed timing constants. No dependencies.
package bed_pkg;

  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NOW_W = 31;
  localparam int HOLD_W = 16;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_RISE = 3'd0;
  localparam mode_t MODE_FALL = 3'd1;
  localparam mode_t MODE_BOTH = 3'd2;
  localparam mode_t MODE_LONG = 3'd3;
  localparam mode_t MODE_DBL  = 3'd4;

  localparam cfg_idx_t REG_TRIGGER_MODE = 2'd0;
  localparam cfg_idx_t REG_HOLD_TIME    = 2'd1;

  // double-click window in ms
  localparam int DC_WINDOW = 200;

endpackage

// File: rtl/bed_intf.sv
// Valid/ready channel interfaces for the button event detector:
// sample input, fire result and register write. Depends on bed_pkg.
interface bed_in_if;
  logic                       valid;
  logic                       ready;
  logic                       button_level;
  logic [bed_pkg::NOW_W-1:0]  now_ms;
  modport source (output valid, button_level, now_ms, input ready);
  modport sink   (input valid, button_level, now_ms, output ready);
endinterface

interface bed_out_if;
  logic valid;
  logic ready;
  logic fire;
  modport source (output valid, fire, input ready);
  modport sink   (input valid, fire, output ready);
endinterface

interface bed_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bed_pkg::CFG_IDX_W-1:0]  index;
  logic [bed_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/button_event_detector.sv
// Button event detector, top level: sample register, event logic, state
// and result register. Depends on bed_pkg and the channel interfaces.
//
// One button sample (level plus millisecond time) is taken per transfer and
// gives exactly one fire result. A sample passes an input register, then the
// event logic updates the detector state and loads the result register in
// the same cycle, so a new sample is taken every cycle while the result side
// keeps up; the state update (level flag, start time, released flag) made with
// each result load allows that rate.
// Register 0 selects the trigger mode (rising, falling, both edges, long
// press, double click; codes 5-7 never fire) and re-arms the detector;
// register 1 is the long-press hold time in ms. Write registers only while
// no sample is in flight. Only the low TIME_BITS bits of the time are used.
module button_event_detector #(
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  bed_in_if.sink    in_bus,
  bed_out_if.source out_bus,
  bed_cfg_if.sink   cfg_bus
);
  import bed_pkg::*;

  localparam logic [TIME_BITS-1:0] NONE = '1;

  // configuration
  mode_t               mode_r;
  logic [HOLD_W-1:0]   hold_r;
  // detector state
  logic                level_r, level_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                released_r, released_nxt;
  // pipeline
  logic                in_vld_r;
  logic                in_lvl_r;
  logic [NOW_W-1:0]    in_now_r;
  logic                out_vld_r;
  logic                out_fire_r;
  logic                fire_nxt;

  logic advance;
  logic cfg_wr;
  logic mode_wr;

  logic [31:0]          now32;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS:0]   now_w;
  logic [TIME_BITS:0]   start_w;
  logic                 long_due;
  logic                 dc_expired;
  logic [TIME_BITS-1:0] dc_start;
  logic                 dc_valid;

  assign advance = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || advance;
  assign cfg_bus.ready = 1'b1;
  assign cfg_wr  = cfg_bus.valid && cfg_bus.ready;
  assign mode_wr = cfg_wr && (cfg_bus.index == REG_TRIGGER_MODE);

  assign out_bus.valid = out_vld_r;
  assign out_bus.fire  = out_fire_r;

  assign now32   = {1'b0, in_now_r};
  assign now_t   = now32[TIME_BITS-1:0];
  assign now_w   = {1'b0, now_t};
  assign start_w = {1'b0, start_r};

  assign long_due = (start_r != NONE) &&
                    (now_w > start_w + (TIME_BITS+1)'(hold_r));
  // no start counts as -1, so expiry then means now > window - 1
  assign dc_expired = (start_r == NONE) ? (now_w > (TIME_BITS+1)'(DC_WINDOW - 1))
                                        : (start_w + (TIME_BITS+1)'(DC_WINDOW) < now_w);
  assign dc_start = dc_expired ? NONE : start_r;
  assign dc_valid = (dc_start != NONE);

  always_comb begin
    level_nxt    = level_r;
    start_nxt    = start_r;
    released_nxt = released_r;
    fire_nxt     = 1'b0;
    case (mode_r)
      MODE_RISE: begin
        if (!level_r && in_lvl_r) begin
          level_nxt = 1'b1;
          fire_nxt  = 1'b1;
        end else if (!in_lvl_r) begin
          level_nxt = 1'b0;
        end
      end
      MODE_FALL: begin
        if (!level_r && !in_lvl_r) begin
          level_nxt = 1'b1;
          fire_nxt  = 1'b1;
        end else if (in_lvl_r) begin
          level_nxt = 1'b0;
        end
      end
      MODE_BOTH: begin
        if (level_r != in_lvl_r) begin
          level_nxt = in_lvl_r;
          fire_nxt  = 1'b1;
        end
      end
      MODE_LONG: begin
        if (!level_r && in_lvl_r) begin
          level_nxt = 1'b1;
          start_nxt = now_t;
        end else if (!in_lvl_r) begin
          level_nxt = 1'b0;
          start_nxt = NONE;
        end else if (long_due) begin
          fire_nxt  = 1'b1;
          start_nxt = NONE;
        end
      end
      MODE_DBL: begin
        start_nxt    = dc_start;
        released_nxt = dc_expired ? 1'b0 : released_r;
        if (!level_r && !released_nxt && in_lvl_r) begin
          start_nxt = now_t;
          level_nxt = 1'b1;
        end else if (level_r && !released_nxt && dc_valid && !in_lvl_r) begin
          released_nxt = 1'b1;
        end else if (level_r && released_nxt && dc_valid && in_lvl_r) begin
          fire_nxt  = 1'b1;
          start_nxt = NONE;
        end else if (!dc_valid) begin
          level_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RISE;
      hold_r     <= '0;
      level_r    <= 1'b0;
      start_r    <= NONE;
      released_r <= 1'b0;
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        in_vld_r <= in_bus.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
      if (mode_wr) begin
        // a mode write re-arms the detector
        mode_r     <= cfg_bus.data[MODE_W-1:0];
        level_r    <= (cfg_bus.data[MODE_W-1:0] == MODE_FALL);
        start_r    <= NONE;
        released_r <= 1'b0;
      end else if (advance) begin
        level_r    <= level_nxt;
        start_r    <= start_nxt;
        released_r <= released_nxt;
      end
      if (cfg_wr && (cfg_bus.index == REG_HOLD_TIME)) begin
        hold_r <= cfg_bus.data[HOLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_lvl_r <= in_bus.button_level;
      in_now_r <= in_bus.now_ms;
    end
    if (advance) begin
      out_fire_r <= fire_nxt;
    end
  end

  a_mode_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    mode_wr |=> (start_r == NONE) && !released_r && (level_r == (mode_r == MODE_FALL)))
    else $error("mode write did not re-arm detector");

  a_long_start_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_LONG) && (start_r != NONE) |-> level_r)
    else $error("long-press start held without press");

  a_released_dbl_only: assert property (@(posedge clk) disable iff (!rst_n)
    released_r |-> (mode_r == MODE_DBL))
    else $error("released flag set outside double-click mode");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_bus.ready |=> out_vld_r && $stable(out_fire_r))
    else $error("stalled result changed");

endmodule
